// ===== sv/asc_pkg.sv =====
package asc_pkg;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_ALARM_HOUR       = 3'd0,
    REG_ALARM_MINUTE     = 3'd1,
    REG_ALARM_SECOND     = 3'd2,
    REG_TICKS_PER_SECOND = 3'd3,
    REG_NOTIFY_MINUTES   = 3'd4,
    REG_WAIT_MINUTES     = 3'd5,
    REG_MAX_SNOOZES      = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_CLOCK       = 2'd0,
    MODE_NOTIFY      = 2'd1,
    MODE_ALARM_WAIT  = 2'd2,
    MODE_SNOOZE_WAIT = 2'd3
  } mode_e;

  localparam logic [5:0] LastSecond  = 6'd59;
  localparam logic [5:0] LastMinute  = 6'd59;
  localparam logic [3:0] SnoozeLimit = 4'd15;

  localparam logic [4:0] RstAlarmHour   = 5'd0;
  localparam logic [5:0] RstAlarmMinute = 6'd0;
  localparam logic [5:0] RstAlarmSecond = 6'd0;
  localparam logic [7:0] RstTicksPerSec = 8'd100;
  localparam logic [5:0] RstNotifyMin   = 6'd1;
  localparam logic [5:0] RstWaitMin     = 6'd5;
  localparam logic [3:0] RstMaxSnoozes  = 4'd3;

  typedef struct packed {
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
    logic [5:0] clock_second;
    logic       stop_pressed;
    logic       snooze_pressed;
  } req_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       notify_active;
    logic [3:0] snooze_count;
  } rsp_t;

  typedef struct packed {
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic [5:0] alarm_second;
    logic [7:0] ticks_per_second;
    logic [5:0] notify_minutes;
    logic [5:0] wait_minutes;
    logic [3:0] max_snoozes;
  } cfg_t;

  // tick counter reload from the remainder unit
  typedef struct packed {
    logic       load;
    logic [7:0] value;
  } tick_load_t;

  // a rate of zero behaves as one tick per second
  function automatic logic [7:0] eff_tps(input logic [7:0] tps);
    return (tps == 8'd0) ? 8'd1 : tps;
  endfunction

endpackage

// ===== sv/asc_req_if.sv =====
interface asc_req_if;
  import asc_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/asc_rsp_if.sv =====
interface asc_rsp_if;
  import asc_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/alarm_snooze_controller_unit.sv =====
// channel   dir  modport  payload                                          handshake
// req_i     in   sink     clock_hour, clock_minute, clock_second, buttons  valid/ready
// rsp_o     out  source   mode, notify_active, snooze_count                valid/ready
// cfg       in   -        cfg_idx_i, cfg_wdata_i                           cfg_we_i only
//
// one request per cycle sustained while the result side is ready and no fold runs; the
// input register loads when a request is taken and the mode step then fills the result
// register from it, so each result passes the input register and then the result register
// writing ticks_per_second starts a remainder pass over the tick counter, one quotient
// bit per cycle, and no request is taken while it runs
// reset: clock mode, all counters and held time zero, registers at their defaults
// a stalled result holds in the result register; the input register keeps
// taking requests until both stages are full
module alarm_snooze_controller_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  asc_req_if.sink      req_i,
  asc_rsp_if.source    rsp_o,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [7:0]   cfg_wdata_i
);
  import asc_pkg::*;

  // configuration registers
  cfg_t       cfg_q;

  // input stage
  logic       s1_valid_q, s1_valid_d;
  req_t       s1_data_q;
  logic       s1_adv;

  // core and remainder unit hookup
  logic       core_ready;
  logic       core_valid;
  rsp_t       core_data;
  logic [7:0] core_tick;
  logic       rem_busy;
  logic       rem_start;
  tick_load_t tick_load;

  // input stage moves when it is empty or the core takes its request
  assign s1_adv      = !s1_valid_q || core_ready;
  assign req_i.ready = s1_adv && !rem_busy;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_adv) begin
      s1_valid_d = req_i.valid && !rem_busy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_data_q <= req_i.data;
    end
  end

  // register writes, indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alarm_hour       <= RstAlarmHour;
      cfg_q.alarm_minute     <= RstAlarmMinute;
      cfg_q.alarm_second     <= RstAlarmSecond;
      cfg_q.ticks_per_second <= RstTicksPerSec;
      cfg_q.notify_minutes   <= RstNotifyMin;
      cfg_q.wait_minutes     <= RstWaitMin;
      cfg_q.max_snoozes      <= RstMaxSnoozes;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ALARM_HOUR:       cfg_q.alarm_hour       <= cfg_wdata_i[4:0];
        REG_ALARM_MINUTE:     cfg_q.alarm_minute     <= cfg_wdata_i[5:0];
        REG_ALARM_SECOND:     cfg_q.alarm_second     <= cfg_wdata_i[5:0];
        REG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= cfg_wdata_i;
        REG_NOTIFY_MINUTES:   cfg_q.notify_minutes   <= cfg_wdata_i[5:0];
        REG_WAIT_MINUTES:     cfg_q.wait_minutes     <= cfg_wdata_i[5:0];
        REG_MAX_SNOOZES:      cfg_q.max_snoozes      <= cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // a new rate may sit below the current count, so fold the count into range
  assign rem_start = cfg_we_i && (cfg_idx_i == REG_TICKS_PER_SECOND);

  asc_tick_rem u_tick_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .divisor_i  (cfg_wdata_i),
    .dividend_i (core_tick),
    .busy_o     (rem_busy),
    .load_o     (tick_load)
  );

  asc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .tick_load_i (tick_load),
    .in_valid_i  (s1_valid_q),
    .in_data_i   (s1_data_q),
    .in_ready_o  (core_ready),
    .out_valid_o (core_valid),
    .out_data_o  (core_data),
    .out_ready_i (rsp_o.ready),
    .tick_o      (core_tick)
  );

  assign rsp_o.valid = core_valid;
  assign rsp_o.data  = core_data;

`ifndef SYNTH
  // no request gets in while the tick counter is being folded
  a_busy_blocks_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_busy |-> !req_i.ready)
    else $error("request taken during tick counter fold");

  // a taken request always lands in the input stage
  a_req_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> s1_valid_q)
    else $error("accepted request lost");

  // the fold ends with its reload unless a new rate write restarts it
  a_fold_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_load.load && !rem_start) |=> !rem_busy)
    else $error("fold still busy after reload");
`endif

endmodule

// ===== sv/asc_tick_rem.sv =====
module asc_tick_rem (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [7:0]             divisor_i,
  input  logic [7:0]             dividend_i,
  output logic                   busy_o,
  output asc_pkg::tick_load_t    load_o
);
  import asc_pkg::*;

  logic       busy_q, busy_d;
  logic [2:0] cnt_q, cnt_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] dvd_q;
  logic [7:0] div_q;
  logic [8:0] trial;
  logic [8:0] diff;
  logic [7:0] rem_step;

  // one restoring step per cycle, msb first
  assign trial    = {rem_q, dvd_q[cnt_q]};
  assign diff     = trial - {1'b0, div_q};
  assign rem_step = (trial >= {1'b0, div_q}) ? diff[7:0] : trial[7:0];

  assign busy_o       = busy_q;
  assign load_o.load  = busy_q && (cnt_q == 3'd0);
  assign load_o.value = rem_step;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'd7;
      rem_d  = 8'd0;
    end else if (busy_q) begin
      rem_d = rem_step;
      cnt_d = cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= eff_tps(divisor_i);
    end
  end

endmodule

// ===== sv/asc_core.sv =====
module asc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  asc_pkg::cfg_t        cfg_i,
  input  asc_pkg::tick_load_t  tick_load_i,
  input  logic                 in_valid_i,
  input  asc_pkg::req_t        in_data_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output asc_pkg::rsp_t        out_data_o,
  input  logic                 out_ready_i,
  output logic [7:0]           tick_o
);
  import asc_pkg::*;

  mode_e      mode_q, mode_d;
  logic [7:0] tick_q, tick_d;
  logic [4:0] held_hour_q, held_hour_d;
  logic [5:0] held_min_q, held_min_d;
  logic [5:0] held_sec_q, held_sec_d;
  logic [5:0] el_sec_q, el_sec_d;
  logic [5:0] el_min_q, el_min_d;
  logic       snz_used_q, snz_used_d;
  logic [3:0] snz_taken_q, snz_taken_d;
  logic       out_valid_q, out_valid_d;
  rsp_t       out_q, out_d;

  logic       fire;
  logic [7:0] tps;
  logic [7:0] tick_mod;
  logic [7:0] tick_nxt;
  logic       sec_tick;
  logic       alarm_hit;
  logic       go;
  mode_e      target;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign tick_o      = tick_q;

  // counter never exceeds the rate outside a reload, so the wrap is a compare
  assign tps      = eff_tps(cfg_i.ticks_per_second);
  assign tick_mod = (tick_q == tps) ? 8'd0 : tick_q;
  assign tick_nxt = tick_mod + 8'd1;
  assign sec_tick = (tick_nxt == tps);

  always_comb begin
    mode_d      = mode_q;
    tick_d      = tick_q;
    held_hour_d = held_hour_q;
    held_min_d  = held_min_q;
    held_sec_d  = held_sec_q;
    el_sec_d    = el_sec_q;
    el_min_d    = el_min_q;
    snz_used_d  = snz_used_q;
    snz_taken_d = snz_taken_q;
    out_d       = out_q;
    go          = 1'b0;
    target      = mode_q;
    alarm_hit   = 1'b0;

    if (fire) begin
      tick_d = tick_nxt;
      if (sec_tick) begin
        held_hour_d = in_data_i.clock_hour;
        held_min_d  = in_data_i.clock_minute;
        held_sec_d  = in_data_i.clock_second;
        if (el_sec_q >= LastSecond) begin
          el_sec_d = 6'd0;
          el_min_d = (el_min_q >= LastMinute) ? 6'd0 : el_min_q + 6'd1;
        end else begin
          el_sec_d = el_sec_q + 6'd1;
        end
      end

      alarm_hit = (held_hour_d == cfg_i.alarm_hour) &&
                  (held_min_d == cfg_i.alarm_minute) &&
                  (held_sec_d == cfg_i.alarm_second);

      unique case (mode_q)
        MODE_CLOCK: begin
          if (alarm_hit) begin
            snz_used_d  = 1'b0;
            snz_taken_d = 4'd0;
            go          = 1'b1;
            target      = MODE_NOTIFY;
          end
        end
        MODE_NOTIFY: begin
          if (in_data_i.stop_pressed) begin
            go     = 1'b1;
            target = MODE_CLOCK;
          end else if (!snz_used_q && in_data_i.snooze_pressed) begin
            snz_used_d = 1'b1;
            go         = 1'b1;
            target     = MODE_SNOOZE_WAIT;
          end else if (el_min_d == cfg_i.notify_minutes) begin
            go = 1'b1;
            if (snz_used_q) begin
              if (snz_taken_q < SnoozeLimit) begin
                snz_taken_d = snz_taken_q + 4'd1;
              end
              target = MODE_SNOOZE_WAIT;
            end else begin
              target = MODE_ALARM_WAIT;
            end
          end
        end
        MODE_ALARM_WAIT: begin
          if (in_data_i.stop_pressed) begin
            go     = 1'b1;
            target = MODE_CLOCK;
          end else if (el_min_d == cfg_i.wait_minutes) begin
            go     = 1'b1;
            target = MODE_NOTIFY;
          end
        end
        MODE_SNOOZE_WAIT: begin
          if (in_data_i.stop_pressed || (snz_taken_q == cfg_i.max_snoozes)) begin
            go     = 1'b1;
            target = MODE_CLOCK;
          end else if (el_min_d == cfg_i.wait_minutes) begin
            go     = 1'b1;
            target = MODE_NOTIFY;
          end
        end
      endcase

      // every mode change restarts the elapsed time
      if (go) begin
        mode_d   = target;
        el_sec_d = 6'd0;
        el_min_d = 6'd0;
      end

      out_d.mode          = mode_d;
      out_d.notify_active = (mode_q == MODE_NOTIFY);
      out_d.snooze_count  = snz_taken_d;
    end else if (tick_load_i.load) begin
      tick_d = tick_load_i.value;
    end

    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CLOCK;
      tick_q      <= 8'd0;
      held_hour_q <= 5'd0;
      held_min_q  <= 6'd0;
      held_sec_q  <= 6'd0;
      el_sec_q    <= 6'd0;
      el_min_q    <= 6'd0;
      snz_used_q  <= 1'b0;
      snz_taken_q <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      tick_q      <= tick_d;
      held_hour_q <= held_hour_d;
      held_min_q  <= held_min_d;
      held_sec_q  <= held_sec_d;
      el_sec_q    <= el_sec_d;
      el_min_q    <= el_min_d;
      snz_used_q  <= snz_used_d;
      snz_taken_q <= snz_taken_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ===== test/alarm_snooze_controller_unit_tb.sv =====
module alarm_snooze_controller_unit_tb;
  import asc_pkg::*;

  // handshake idling switches after this many requests
  localparam int PhaseLen = 485;
  // run limit in time units, far above the slowest legal run
  localparam int RunLimit = 800000;

  logic clk = 1'b0;
  logic rst_n;
  logic       cfg_we;
  logic [2:0] cfg_idx;
  logic [7:0] cfg_wdata;

  asc_req_if req_if ();
  asc_rsp_if rsp_if ();

  alarm_snooze_controller_unit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // alarm model state, kept in step with every accepted request
  // ---------------------------------------------------------------------------
  cfg_t       cfg_m;
  mode_e      cur_mode;
  logic [7:0] tick_cnt;
  logic [4:0] held_hr;
  logic [5:0] held_min;
  logic [5:0] held_sec;
  logic [5:0] el_sec;
  logic [5:0] el_min;
  logic       snooze_used;
  logic [3:0] snoozes;

  // expected status words, oldest first
  rsp_t pending_status[$];

  int send_idle_pct = 10;
  int recv_idle_pct = 79;
  int sent_count    = 0;
  int checked_count = 0;
  int reg_writes    = 0;
  int error_count   = 0;
  logic [3:0] modes_seen   = '0;
  logic [3:0] peak_snoozes = '0;

  // every mode change restarts the elapsed counter
  function automatic void switch_mode(input mode_e m);
    cur_mode = m;
    el_sec   = '0;
    el_min   = '0;
  endfunction

  // one timer tick: second handling first, then the mode machine
  function automatic rsp_t next_alarm_status(input req_t r);
    rsp_t       o;
    logic [7:0] tps;
    o.notify_active = (cur_mode == MODE_NOTIFY);
    // a rate of zero counts as one tick per second
    tps = (cfg_m.ticks_per_second == 8'd0) ? 8'd1 : cfg_m.ticks_per_second;
    // the remainder pulls a count above a lowered rate back into range
    tick_cnt = (tick_cnt % tps) + 8'd1;
    if (tick_cnt == tps) begin
      held_hr  = r.clock_hour;
      held_min = r.clock_minute;
      held_sec = r.clock_second;
      if (el_sec == 6'd59) begin
        el_sec = '0;
        el_min = (el_min == 6'd59) ? 6'd0 : el_min + 6'd1;
      end else begin
        el_sec = el_sec + 6'd1;
      end
    end
    case (cur_mode)
      MODE_CLOCK: begin
        // held time compared bit for bit, even out of range
        if (held_hr == cfg_m.alarm_hour && held_min == cfg_m.alarm_minute &&
            held_sec == cfg_m.alarm_second) begin
          snooze_used = 1'b0;
          snoozes     = '0;
          switch_mode(MODE_NOTIFY);
        end
      end
      MODE_NOTIFY: begin
        if (r.stop_pressed) begin
          switch_mode(MODE_CLOCK);
        end else if (!snooze_used && r.snooze_pressed) begin
          // the button works once per episode
          snooze_used = 1'b1;
          switch_mode(MODE_SNOOZE_WAIT);
        end else if (el_min == cfg_m.notify_minutes) begin
          if (snooze_used) begin
            // automatic snooze, count saturates
            if (snoozes != SnoozeLimit) snoozes = snoozes + 4'd1;
            switch_mode(MODE_SNOOZE_WAIT);
          end else begin
            switch_mode(MODE_ALARM_WAIT);
          end
        end
      end
      MODE_ALARM_WAIT: begin
        if (r.stop_pressed) switch_mode(MODE_CLOCK);
        else if (el_min == cfg_m.wait_minutes) switch_mode(MODE_NOTIFY);
      end
      default: begin
        if (r.stop_pressed) switch_mode(MODE_CLOCK);
        else if (snoozes == cfg_m.max_snoozes) switch_mode(MODE_CLOCK);
        else if (el_min == cfg_m.wait_minutes) switch_mode(MODE_NOTIFY);
      end
    endcase
    o.mode         = cur_mode;
    o.snooze_count = snoozes;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    error_count++;
    $display("error at result %0d: %s", checked_count, msg);
  endtask

  task automatic check_status(input rsp_t got);
    rsp_t want;
    if (pending_status.size() == 0) begin
      report_mismatch($sformatf("status %h with no request outstanding", got));
    end else begin
      want = pending_status.pop_front();
      if (got.mode !== want.mode)
        report_mismatch($sformatf("mode %0d, expected %0d", got.mode, want.mode));
      if (got.notify_active !== want.notify_active)
        report_mismatch($sformatf("notify_active %0d, expected %0d",
                                  got.notify_active, want.notify_active));
      if (got.snooze_count !== want.snooze_count)
        report_mismatch($sformatf("snooze_count %0d, expected %0d",
                                  got.snooze_count, want.snooze_count));
      modes_seen[want.mode] = 1'b1;
      if (want.snooze_count > peak_snoozes) peak_snoozes = want.snooze_count;
    end
    checked_count++;
  endtask

  // result side: sample the handshake of the ending cycle, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) check_status(rsp_if.data);
    rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // request side and configuration
  // ---------------------------------------------------------------------------
  task automatic send_request(input req_t r);
    // optional gap before this request, valid held low throughout
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_status.push_back(next_alarm_status(r));
    sent_count++;
    // idling regimes: sender light and receiver heavy, then swapped, then none
    if (sent_count == PhaseLen) begin
      send_idle_pct = 79;
      recv_idle_pct = 10;
    end else if (sent_count == 2 * PhaseLen) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // drain all outstanding results, then let the two pipeline stages settle
  task automatic wait_for_idle();
    req_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // bits above the register width are random and must be ignored
  task automatic write_reg(input cfg_reg_e idx, input logic [7:0] value,
                           input logic [7:0] mask);
    logic [7:0] junk;
    junk      = 8'($urandom_range(255));
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= (value & mask) | (junk & ~mask);
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic apply_config(input cfg_t c);
    wait_for_idle();
    write_reg(REG_ALARM_HOUR, 8'(c.alarm_hour), 8'h1f);
    write_reg(REG_ALARM_MINUTE, 8'(c.alarm_minute), 8'h3f);
    write_reg(REG_ALARM_SECOND, 8'(c.alarm_second), 8'h3f);
    write_reg(REG_TICKS_PER_SECOND, c.ticks_per_second, 8'hff);
    write_reg(REG_NOTIFY_MINUTES, 8'(c.notify_minutes), 8'h3f);
    write_reg(REG_WAIT_MINUTES, 8'(c.wait_minutes), 8'h3f);
    write_reg(REG_MAX_SNOOZES, 8'(c.max_snoozes), 8'h0f);
    cfg_we <= 1'b0;
    cfg_m = c;
  endtask

  function automatic cfg_t make_cfg(input int hr, input int mn, input int sc, input int tps,
                                    input int notify_m, input int wait_m, input int limit);
    cfg_t c;
    c.alarm_hour       = 5'(hr);
    c.alarm_minute     = 6'(mn);
    c.alarm_second     = 6'(sc);
    c.ticks_per_second = 8'(tps);
    c.notify_minutes   = 6'(notify_m);
    c.wait_minutes     = 6'(wait_m);
    c.max_snoozes      = 4'(limit);
    return c;
  endfunction

  function automatic req_t mk(input int hr, input int mn, input int sc,
                              input bit stop, input bit snz);
    req_t r;
    r.clock_hour     = 5'(hr);
    r.clock_minute   = 6'(mn);
    r.clock_second   = 6'(sc);
    r.stop_pressed   = stop;
    r.snooze_pressed = snz;
    return r;
  endfunction

  // alarm-hitting wall time on 40 percent of clock-mode ticks, otherwise noise;
  // buttons given in parts per thousand, stop pressed freely in clock mode
  function automatic req_t random_tick(input int stop_pm, input int snooze_pm);
    req_t r;
    if (cur_mode == MODE_CLOCK && $urandom_range(99) < 40) begin
      r.clock_hour   = cfg_m.alarm_hour;
      r.clock_minute = cfg_m.alarm_minute;
      r.clock_second = cfg_m.alarm_second;
    end else if ($urandom_range(1) == 0) begin
      r.clock_hour   = 5'($urandom_range(23));
      r.clock_minute = 6'($urandom_range(59));
      r.clock_second = 6'($urandom_range(59));
    end else begin
      r.clock_hour   = 5'($urandom_range(31));
      r.clock_minute = 6'($urandom_range(63));
      r.clock_second = 6'($urandom_range(63));
    end
    r.stop_pressed   = ($urandom_range(999) < ((cur_mode == MODE_CLOCK) ? 50 : stop_pm));
    r.snooze_pressed = ($urandom_range(999) < snooze_pm);
    return r;
  endfunction

  task automatic run_setting(input cfg_t c, input int n_items,
                             input int stop_pm, input int snooze_pm);
    apply_config(c);
    repeat (n_items) send_request(random_tick(stop_pm, snooze_pm));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // alarm entry from reset, button priority, tick wrap and zero timeouts
  task automatic test_alarm_entry_and_buttons();
    // reset settings: held time and alarm both 0:00:00, so notify at once
    send_request(mk(0, 0, 0, 0, 0));
    send_request(mk(0, 0, 0, 0, 1));   // one-shot snooze
    send_request(mk(0, 0, 0, 0, 1));   // snooze wait ignores the button
    send_request(mk(0, 0, 0, 1, 0));   // stop back to clock
    send_request(mk(31, 63, 63, 0, 0)); // held time still matches after stop
    send_request(mk(31, 63, 63, 1, 1)); // stop wins over snooze
    send_request(mk(0, 0, 0, 0, 0));
    send_request(mk(0, 0, 0, 1, 0));
    // rate lowered below the running tick count, out-of-range alarm time,
    // timeouts of zero that fire right after each mode change
    apply_config(make_cfg(31, 63, 63, 4, 0, 0, 2));
    repeat (4) send_request(mk(31, 63, 63, 0, 0));
    send_request(mk(0, 0, 0, 0, 0));   // notify times out into alarm wait
    send_request(mk(0, 0, 0, 0, 0));   // alarm wait back to notify
    send_request(mk(0, 0, 0, 0, 1));   // snooze used
    repeat (5) send_request(mk(0, 0, 0, 0, 0)); // auto snoozes up to the limit
    send_request(mk(0, 0, 0, 0, 0));   // held time no longer matches, clock mode stays
    send_request(mk(0, 0, 0, 1, 0));
  endtask

  // whole alarm episodes: notify, waits, automatic snoozes up to the limit
  task automatic test_snooze_episodes();
    run_setting(make_cfg($urandom_range(23), $urandom_range(59), $urandom_range(59),
                         1, 1, 1, 1), 180, 3, 10);
    run_setting(make_cfg($urandom_range(23), $urandom_range(59), $urandom_range(59),
                         1, 1, 1, 3), 250, 2, 30);
    run_setting(make_cfg($urandom_range(23), $urandom_range(59), $urandom_range(59),
                         1, 2, 1, 2), 250, 2, 10);
    run_setting(make_cfg($urandom_range(23), $urandom_range(59), $urandom_range(59),
                         2, 1, 1, 1), 200, 3, 15);
    run_setting(make_cfg(23, 59, 59, 1, 1, 1, 15), 150, 3, 20);
    run_setting(make_cfg($urandom_range(23), $urandom_range(59), $urandom_range(59),
                         1, 1, 1, 2), 140, 4, 10);
  endtask

  // register extremes and values outside the documented ranges
  task automatic test_edge_settings();
    run_setting(make_cfg(0, 0, 0, 0, 0, 0, 0), 60, 20, 50);      // zero rate and limits
    run_setting(make_cfg(0, 0, 0, 255, 59, 59, 0), 80, 20, 50);  // slowest rate
    run_setting(make_cfg(31, 63, 63, 1, 63, 63, 1), 60, 20, 50); // unreachable timeouts
    run_setting(make_cfg($urandom_range(23), $urandom_range(59), $urandom_range(59),
                         1, 59, 59, 0), 60, 20, 50);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= REG_ALARM_HOUR;
    cfg_wdata    <= '0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    // model starts from the reset values
    cfg_m       = make_cfg(RstAlarmHour, RstAlarmMinute, RstAlarmSecond, RstTicksPerSec,
                           RstNotifyMin, RstWaitMin, RstMaxSnoozes);
    cur_mode    = MODE_CLOCK;
    tick_cnt    = '0;
    held_hr     = '0;
    held_min    = '0;
    held_sec    = '0;
    el_sec      = '0;
    el_min      = '0;
    snooze_used = 1'b0;
    snoozes     = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_alarm_entry_and_buttons();
    test_snooze_episodes();
    test_edge_settings();

    // every result back, then a few more cycles for stray outputs
    wait_for_idle();
    repeat (6) @(posedge clk);

    $display("run covered %0d timer ticks, %0d status words checked, %0d register writes",
             sent_count, checked_count, reg_writes);
    $display("modes reached %b, highest automatic snooze count %0d", modes_seen, peak_snoozes);
    if (error_count == 0 && pending_status.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #RunLimit;
    $display("timeout with %0d results outstanding", pending_status.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/asc_pkg.sv
sv/asc_req_if.sv
sv/asc_rsp_if.sv
sv/asc_tick_rem.sv
sv/asc_core.sv
sv/alarm_snooze_controller_unit.sv
test/alarm_snooze_controller_unit_tb.sv
